// ===== rtl/ird_pkg.sv =====
package ird_pkg;

	localparam int VALUE_BITS = 32;
	localparam int VALUE_W = 32;
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W = 7;
	localparam int ADDR_W = $clog2(VALUE_BITS);
	localparam int COUNT_W = $clog2(VALUE_BITS + 1);

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);
	localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_A_OFS = CHAR_W'(55);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_STORE,
		S_RD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic step;
	} div_ctrl_t;

	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d < DIGIT_W'(10)) begin
			res = CHAR_ZERO + CHAR_W'(d);
		end else begin
			res = CHAR_A_OFS + CHAR_W'(d);
		end
		return res;
	endfunction

endpackage

// ===== rtl/ird_value_if.sv =====
interface ird_value_if
	import ird_pkg::*;
();
	logic valid;
	logic ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ===== rtl/ird_digit_if.sv =====
interface ird_digit_if
	import ird_pkg::*;
();
	logic valid;
	logic ready;
	logic [CHAR_W-1:0] digit_char;
	logic [DIGIT_W-1:0] digit_value;
	logic last_digit;

	modport source (output valid, output digit_char, output digit_value, output last_digit,
		input ready);
	modport sink (input valid, input digit_char, input digit_value, input last_digit,
		output ready);
endinterface

// ===== rtl/ird_divider.sv =====
module ird_divider
	import ird_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  div_ctrl_t ctrl,
	input  logic [VALUE_BITS-1:0] load_val,
	input  logic [RADIX_W-1:0] base,
	output logic q_zero,
	output logic [DIGIT_W-1:0] rem
);

	logic [VALUE_BITS-1:0] quot_q;
	logic [RADIX_W-1:0] rem_q;
	logic [RADIX_W-1:0] rem_shift;
	logic ge;

	// Restoring division, one quotient bit per cycle. The remainder stays
	// below the base, so five bits hold the shifted partial remainder.
	assign rem_shift = {rem_q[RADIX_W-2:0], quot_q[VALUE_BITS-1]};
	assign ge = (rem_shift >= base);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
			rem_q <= '0;
		end else begin
			if (ctrl.load) begin
				quot_q <= load_val;
			end else if (ctrl.step) begin
				quot_q <= {quot_q[VALUE_BITS-2:0], ge};
			end
			if (ctrl.clear) begin
				rem_q <= '0;
			end else if (ctrl.step) begin
				rem_q <= ge ? (rem_shift - base) : rem_shift;
			end
		end
	end

	assign q_zero = (quot_q == '0);
	assign rem = rem_q[DIGIT_W-1:0];

endmodule

// ===== rtl/ird_digit_mem.sv =====
module ird_digit_mem
	import ird_pkg::*;
(
	input  logic clk,
	input  logic we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DIGIT_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DIGIT_W-1:0] rdata
);

	logic [DIGIT_W-1:0] digits_q [VALUE_BITS];
	logic [DIGIT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			digits_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= digits_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/integer_to_radix_digits.sv =====
// Converts one unsigned integer to digits of a base from 2 to 16.
//
// The src channel takes one 32-bit value per beat. The dst channel gives one
// beat per digit, most significant first: the ASCII character, the digit's
// value, and last_digit set on the final, least significant digit. A value of
// zero gives the single digit '0'. The radix register is written with
// radix_we; values below 2 act as 2 and values above 16 act as 16.
//
// Each digit costs one division pass through a bit-serial divider of one
// quotient bit per cycle (test, 32 steps, store), plus one final test
// state. The digits are then read back from the digit memory, each through
// a read state and an output state, as its read port is registered. One
// value is converted at a time.
//
// Reset clears the control state and sets the radix to 2. When the receiver
// stalls, the current digit is held in the output register and the readout
// waits; the last digit may still be waiting when the next value is taken.
module integer_to_radix_digits
	import ird_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic radix_we,
	input  logic [RADIX_W-1:0] radix,
	ird_value_if.sink src,
	ird_digit_if.source dst
);

	state_t state_q, state_d;
	logic [RADIX_W-1:0] radix_q;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [ADDR_W-1:0] bit_q, bit_d;
	logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
	logic out_valid_q, out_valid_d;
	logic [DIGIT_W-1:0] out_digit_q;
	logic out_last_q;
	logic out_load;
	logic [COUNT_W-1:0] cnt_m1;

	div_ctrl_t div_ctrl;
	logic q_zero;
	logic [DIGIT_W-1:0] rem;
	logic mem_we;
	logic [DIGIT_W-1:0] mem_wdata;
	logic [DIGIT_W-1:0] mem_rdata;

	ird_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.load_val (VALUE_BITS'(src.value)),
		.base     (eff_radix(radix_q)),
		.q_zero   (q_zero),
		.rem      (rem)
	);

	ird_digit_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (mem_wdata),
		.raddr (rd_ptr_q),
		.rdata (mem_rdata)
	);

	assign cnt_m1 = count_q - COUNT_W'(1);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		bit_d = bit_q;
		rd_ptr_d = rd_ptr_q;
		div_ctrl = '0;
		mem_we = 1'b0;
		mem_wdata = rem;
		out_load = 1'b0;
		src.ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				src.ready = 1'b1;
				if (src.valid) begin
					div_ctrl.load = 1'b1;
					count_d = '0;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (q_zero || count_q == COUNT_W'(VALUE_BITS)) begin
					if (count_q == '0) begin
						// Zero input still yields one digit.
						mem_we = 1'b1;
						mem_wdata = '0;
						count_d = COUNT_W'(1);
						rd_ptr_d = '0;
					end else begin
						rd_ptr_d = cnt_m1[ADDR_W-1:0];
					end
					state_d = S_RD;
				end else begin
					div_ctrl.clear = 1'b1;
					bit_d = '0;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				div_ctrl.step = 1'b1;
				bit_d = bit_q + ADDR_W'(1);
				if (bit_q == ADDR_W'(VALUE_BITS - 1)) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				mem_we = 1'b1;
				count_d = count_q + COUNT_W'(1);
				state_d = S_CHECK;
			end
			S_RD: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || dst.ready) begin
					out_load = 1'b1;
					if (rd_ptr_q == '0) begin
						state_d = S_IDLE;
					end else begin
						rd_ptr_d = rd_ptr_q - ADDR_W'(1);
						state_d = S_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (dst.ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			radix_q <= RADIX_MIN;
			count_q <= '0;
			bit_q <= '0;
			rd_ptr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (radix_we) begin
				radix_q <= radix;
			end
			count_q <= count_d;
			bit_q <= bit_d;
			rd_ptr_q <= rd_ptr_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_digit_q <= mem_rdata;
			out_last_q <= (rd_ptr_q == '0);
		end
	end

	assign dst.valid = out_valid_q;
	assign dst.digit_value = out_digit_q;
	assign dst.digit_char = ascii_of(out_digit_q);
	assign dst.last_digit = out_last_q;

endmodule
